// File: hdl/nbt_pkg.sv
// Package for the naive Bayes train/predict engine: shared constants, codes,
// the log2 fraction table and the lane control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nbt_pkg;

    localparam int NUM_FEATURES_DEF = 8;
    localparam int MAX_CLASSES_DEF  = 8;
    localparam int MAX_LEVELS_DEF   = 16;
    localparam int COUNT_WIDTH_DEF  = 32;

    // Fixed field widths of the item and of the registers.
    localparam int FEAT_SLOTS = 8;
    localparam int FEAT_W     = 5;
    localparam int CLS_REG_W  = 4;
    localparam int LVL_REG_W  = 40;
    localparam int APB_DW     = 64;
    localparam int APB_AW     = 4;

    // log2 results: 6-bit exponent over a 16-bit fraction.
    localparam int EXP_W   = 6;
    localparam int LOG_W   = EXP_W + 16;
    localparam int SCORE_W = LOG_W + 5;

    localparam logic [CLS_REG_W-1:0] CLASSES_RST = 4'd8;
    localparam logic [LVL_REG_W-1:0] LEVELS_RST  = 40'd567489872400;
    localparam logic [3:0]           NO_CLASS    = 4'hF;

    // Register select is address bit 3 (registers sit at 8-byte steps).
    localparam logic REG_CLASSES = 1'b0;
    localparam logic REG_LEVELS  = 1'b1;

    typedef enum logic [1:0] {
        OP_TRAIN   = 2'd0,
        OP_PREDICT = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_UNUSED  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        STS_TRAINED   = 3'd0,
        STS_REJECTED  = 3'd1,
        STS_CLEARED   = 3'd2,
        STS_PREDICTED = 3'd3,
        STS_NO_DATA   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TRAIN_RD,
        S_TRAIN_WR,
        S_PRED,
        S_DONE
    } t_state;

    // Control broadcast from the sequencer to every feature lane.
    typedef struct packed {
        logic       inc;
        logic       clr;
        logic [2:0] cls;
        logic [7:0] clr_addr;
    } t_lane_ctl;

    // round(65536 * log2(1 + m/16))
    function automatic logic [15:0] frac_log2(input logic [3:0] m);
        logic [15:0] r;
        case (m)
            4'd0:    r = 16'd0;
            4'd1:    r = 16'd5732;
            4'd2:    r = 16'd11136;
            4'd3:    r = 16'd16248;
            4'd4:    r = 16'd21098;
            4'd5:    r = 16'd25711;
            4'd6:    r = 16'd30109;
            4'd7:    r = 16'd34312;
            4'd8:    r = 16'd38336;
            4'd9:    r = 16'd42196;
            4'd10:   r = 16'd45904;
            4'd11:   r = 16'd49472;
            4'd12:   r = 16'd52911;
            4'd13:   r = 16'd56229;
            4'd14:   r = 16'd59434;
            default: r = 16'd62534;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/nbt_if.sv
// Valid/ready channel interfaces for the input items and the results.
// Depends on nbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface nbt_in_if;
    import nbt_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              opcode;
    logic signed [3:0]       label;
    logic [FEAT_W-1:0]       feature_0;
    logic [FEAT_W-1:0]       feature_1;
    logic [FEAT_W-1:0]       feature_2;
    logic [FEAT_W-1:0]       feature_3;
    logic [FEAT_W-1:0]       feature_4;
    logic [FEAT_W-1:0]       feature_5;
    logic [FEAT_W-1:0]       feature_6;
    logic [FEAT_W-1:0]       feature_7;
    modport source (output valid, opcode, label, feature_0, feature_1, feature_2,
                    feature_3, feature_4, feature_5, feature_6, feature_7,
                    input ready);
    modport sink (input valid, opcode, label, feature_0, feature_1, feature_2,
                  feature_3, feature_4, feature_5, feature_6, feature_7,
                  output ready);
endinterface

interface nbt_out_if;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic signed [3:0] predicted_class;
    modport source (output valid, status, predicted_class, input ready);
    modport sink (input valid, status, predicted_class, output ready);
endinterface
`default_nettype wire

// File: hdl/nbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module nbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: hdl/nbt_log2.sv
// Two-stage fixed-point log2 unit: leading-one search, then mantissa table.
// Depends on nbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nbt_log2 #(
    parameter int XW = 33
) (
    input  wire logic                  i_clk,
    input  wire logic [XW-1:0]         i_x,
    output logic [nbt_pkg::LOG_W-1:0]  o_l
);
    import nbt_pkg::*;

    logic [EXP_W-1:0] e;
    logic [EXP_W-1:0] r_e;
    logic [XW-1:0]    r_x;
    logic [XW-1:0]    shifted;
    logic [3:0]       m;
    logic [LOG_W-1:0] r_l;

    // The highest set bit wins.
    always_comb begin
        e = '0;
        for (int i = 0; i < XW; i++) begin
            if (i_x[i]) begin
                e = EXP_W'(i);
            end
        end
    end

    always_comb begin
        if (r_e >= EXP_W'(4)) begin
            shifted = r_x >> (r_e - EXP_W'(4));
        end else begin
            shifted = r_x << (EXP_W'(4) - r_e);
        end
        m = shifted[3:0];
    end

    always_ff @(posedge i_clk) begin
        r_e <= e;
        r_x <= i_x;
        r_l <= {r_e, frac_log2(m)};
    end

    assign o_l = r_l;
endmodule
`default_nettype wire

// File: hdl/nbt_lane.sv
// One feature lane: owns the (value, class) count table of its feature,
// does the saturating increment and clear sweep, and yields log2(count+1).
// Depends on nbt_pkg, nbt_ram and nbt_log2.
`timescale 1ns / 1ps
`default_nettype none
module nbt_lane #(
    parameter int MAX_CLASSES = 8,
    parameter int MAX_LEVELS  = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire nbt_pkg::t_lane_ctl            i_ctl,
    input  wire logic [nbt_pkg::FEAT_W-1:0]    i_value,
    input  wire logic [nbt_pkg::FEAT_W-1:0]    i_levels,
    output logic      [nbt_pkg::LOG_W-1:0]     o_term
);
    import nbt_pkg::*;

    localparam int DEPTH = MAX_LEVELS * MAX_CLASSES;
    localparam int AW    = $clog2(DEPTH);
    localparam int LVW   = $clog2(MAX_LEVELS);
    localparam int CIW   = $clog2(MAX_CLASSES);
    localparam int XW    = COUNT_WIDTH + 1;

    logic [FEAT_W-1:0]      eff_levels;
    logic                   in_range;
    logic [AW-1:0]          addr;
    logic [COUNT_WIDTH-1:0] rdata;
    logic [COUNT_WIDTH-1:0] wdata;
    logic                   we;
    logic [XW-1:0]          log_x;

    // Level fields above the table size act as the table size.
    assign eff_levels = (i_levels > FEAT_W'(MAX_LEVELS)) ? FEAT_W'(MAX_LEVELS) : i_levels;
    assign in_range   = i_value < eff_levels;

    always_comb begin
        if (i_ctl.clr) begin
            addr = i_ctl.clr_addr[AW-1:0];
        end else begin
            addr = AW'(i_value[LVW-1:0]) * AW'(MAX_CLASSES) + AW'(i_ctl.cls[CIW-1:0]);
        end
    end

    assign we    = i_ctl.clr || (i_ctl.inc && in_range);
    assign wdata = i_ctl.clr ? '0 : ((&rdata) ? rdata : rdata + COUNT_WIDTH'(1));
    assign log_x = in_range ? ({1'b0, rdata} + XW'(1)) : XW'(1);

    nbt_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata (wdata),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    nbt_log2 #(
        .XW (XW)
    ) u_log (
        .i_clk (i_clk),
        .i_x   (log_x),
        .o_l   (o_term)
    );
endmodule
`default_nettype wire

// File: hdl/naive_bayes_train_predict.sv
// One item at a time: train reads and then writes the count tables, predict walks every
// class in use, and clear sweeps all MAX_LEVELS*MAX_CLASSES table entries (128 by default).
// Predict runs a per-class walk through the lane count tables: for each class the read,
// two log2 stages, lane sum and compare run in turn before the next class starts.
// Reset (synchronous, active low) restores the registers and runs the same clearing sweep,
// during which no item is taken; config writes are.
`timescale 1ns / 1ps
`default_nettype none
module naive_bayes_train_predict #(
    parameter int NUM_FEATURES = nbt_pkg::NUM_FEATURES_DEF,
    parameter int MAX_CLASSES  = nbt_pkg::MAX_CLASSES_DEF,
    parameter int MAX_LEVELS   = nbt_pkg::MAX_LEVELS_DEF,
    parameter int COUNT_WIDTH  = nbt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    nbt_in_if.sink                           i_in,
    nbt_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [nbt_pkg::APB_AW-1:0]  paddr,
    input  wire logic [nbt_pkg::APB_DW-1:0]  pwdata,
    output logic      [nbt_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);
    import nbt_pkg::*;

    localparam int DEPTH = MAX_LEVELS * MAX_CLASSES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CIW   = $clog2(MAX_CLASSES);
    localparam int XW    = COUNT_WIDTH + 1;
    localparam int SUM_W = LOG_W + 3;

    // Configuration registers. The write lands on the access cycle; pready is
    // tied high so every access completes without wait states.
    logic [CLS_REG_W-1:0] r_classes;
    logic [LVL_REG_W-1:0] r_levels;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_classes <= CLASSES_RST;
            r_levels  <= LEVELS_RST;
        end else if (cfg_wr) begin
            if (paddr[3] == REG_CLASSES) begin
                r_classes <= pwdata[CLS_REG_W-1:0];
            end else begin
                r_levels <= pwdata[LVL_REG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[3] == REG_LEVELS) begin
            prdata = APB_DW'(r_levels);
        end else begin
            prdata = APB_DW'(r_classes);
        end
    end

    // Effective class count: zero acts as one, anything past the table as the table.
    logic [CLS_REG_W-1:0] ncls;
    always_comb begin
        if (r_classes == '0) begin
            ncls = CLS_REG_W'(1);
        end else if (r_classes > CLS_REG_W'(MAX_CLASSES)) begin
            ncls = CLS_REG_W'(MAX_CLASSES);
        end else begin
            ncls = r_classes;
        end
    end

    // Sequencer state and the latched item.
    t_state                  r_state, n_state;
    logic [FEAT_W-1:0]       r_feat [FEAT_SLOTS];
    logic [FEAT_W-1:0]       in_feat [FEAT_SLOTS];
    logic [CIW-1:0]          r_cls, n_cls;
    logic [2:0]              r_phase, n_phase;
    logic [AW-1:0]           r_clr_cnt, n_clr_cnt;
    logic                    r_clr_rpt, n_clr_rpt;
    logic [COUNT_WIDTH-1:0]  r_cc [MAX_CLASSES];
    logic [COUNT_WIDTH-1:0]  r_total;
    logic                    cnt_zero, cnt_inc;
    logic                    r_found, n_found;
    logic signed [SCORE_W-1:0] r_best, n_best;
    logic [CIW-1:0]          r_best_c, n_best_c;
    logic [2:0]              r_res_status, n_res_status;
    logic [3:0]              r_res_class, n_res_class;
    logic                    r_out_valid, n_out_valid;
    logic [2:0]              r_out_status;
    logic [3:0]              r_out_class;
    logic                    in_xfer, out_load;
    t_lane_ctl               lane_ctl;

    assign in_feat[0] = i_in.feature_0;
    assign in_feat[1] = i_in.feature_1;
    assign in_feat[2] = i_in.feature_2;
    assign in_feat[3] = i_in.feature_3;
    assign in_feat[4] = i_in.feature_4;
    assign in_feat[5] = i_in.feature_5;
    assign in_feat[6] = i_in.feature_6;
    assign in_feat[7] = i_in.feature_7;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;

    // Lanes: one per feature, all stepping on the same class index.
    logic [LOG_W-1:0] lane_term [NUM_FEATURES];

    assign lane_ctl.inc      = (r_state == S_TRAIN_WR);
    assign lane_ctl.clr      = (r_state == S_CLEAR);
    assign lane_ctl.cls      = 3'(r_cls);
    assign lane_ctl.clr_addr = 8'(r_clr_cnt);

    for (genvar f = 0; f < NUM_FEATURES; f++) begin : g_lane
        nbt_lane #(
            .MAX_CLASSES (MAX_CLASSES),
            .MAX_LEVELS  (MAX_LEVELS),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .i_clk    (i_clk),
            .i_ctl    (lane_ctl),
            .i_value  (r_feat[f]),
            .i_levels (r_levels[FEAT_W*f +: FEAT_W]),
            .o_term   (lane_term[f])
        );
    end

    // Class-level logs: the prior numerator, the Laplace denominator and the total.
    // Their inputs are steady for a whole class step, so the log2 register stages stay hidden.
    logic [COUNT_WIDTH-1:0] cc_sel;
    logic [LOG_W-1:0]       l_cc, l_den, l_tot;

    assign cc_sel = r_cc[r_cls];

    nbt_log2 #(.XW(XW)) u_log_cc (
        .i_clk (i_clk),
        .i_x   ({1'b0, cc_sel}),
        .o_l   (l_cc)
    );
    nbt_log2 #(.XW(XW)) u_log_den (
        .i_clk (i_clk),
        .i_x   ({1'b0, cc_sel} + XW'(ncls)),
        .o_l   (l_den)
    );
    nbt_log2 #(.XW(XW)) u_log_tot (
        .i_clk (i_clk),
        .i_x   ({1'b0, r_total}),
        .o_l   (l_tot)
    );

    // Merge stage: lane sum is registered, then the class score is formed
    // and compared against the best so far. Strict compare keeps the first maximum.
    logic [SUM_W-1:0]          lane_sum, r_sum;
    logic signed [SCORE_W-1:0] score;

    always_comb begin
        lane_sum = '0;
        for (int f = 0; f < NUM_FEATURES; f++) begin
            lane_sum = lane_sum + SUM_W'(lane_term[f]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= lane_sum;
    end

    assign score = $signed(SCORE_W'(r_sum) + SCORE_W'(l_cc))
                 - $signed(SCORE_W'(l_tot))
                 - $signed(SCORE_W'(l_den) * SCORE_W'(NUM_FEATURES));

    // Next state and datapath control.
    always_comb begin
        logic [3:0] lab;
        n_state      = r_state;
        n_cls        = r_cls;
        n_phase      = r_phase;
        n_clr_cnt    = r_clr_cnt;
        n_clr_rpt    = r_clr_rpt;
        n_found      = r_found;
        n_best       = r_best;
        n_best_c     = r_best_c;
        n_res_status = r_res_status;
        n_res_class  = r_res_class;
        cnt_zero     = 1'b0;
        cnt_inc      = 1'b0;
        out_load     = 1'b0;
        lab          = i_in.label;

        unique case (r_state)
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + AW'(1);
                if (r_clr_cnt == AW'(DEPTH - 1)) begin
                    n_clr_cnt = '0;
                    if (r_clr_rpt) begin
                        n_res_status = STS_CLEARED;
                        n_res_class  = NO_CLASS;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_res_class = NO_CLASS;
                    case (t_opcode'(i_in.opcode))
                        OP_TRAIN: begin
                            if (lab[3] || (lab >= ncls)) begin
                                n_res_status = STS_REJECTED;
                                n_state      = S_DONE;
                            end else begin
                                n_cls   = lab[CIW-1:0];
                                n_state = S_TRAIN_RD;
                            end
                        end
                        OP_PREDICT: begin
                            if (r_total == '0) begin
                                n_res_status = STS_NO_DATA;
                                n_state      = S_DONE;
                            end else begin
                                n_cls   = '0;
                                n_phase = '0;
                                n_found = 1'b0;
                                n_state = S_PRED;
                            end
                        end
                        OP_CLEAR: begin
                            cnt_zero  = 1'b1;
                            n_clr_cnt = '0;
                            n_clr_rpt = 1'b1;
                            n_state   = S_CLEAR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_TRAIN_RD: begin
                n_state = S_TRAIN_WR;
            end
            S_TRAIN_WR: begin
                cnt_inc      = 1'b1;
                n_res_status = STS_TRAINED;
                n_state      = S_DONE;
            end
            S_PRED: begin
                n_phase = r_phase + 3'd1;
                if (r_phase == 3'd4) begin
                    n_phase = '0;
                    if ((cc_sel != '0) && (!r_found || (score > r_best))) begin
                        n_found  = 1'b1;
                        n_best   = score;
                        n_best_c = r_cls;
                    end
                    if (CLS_REG_W'(r_cls) == ncls - CLS_REG_W'(1)) begin
                        n_res_status = n_found ? STS_PREDICTED : STS_NO_DATA;
                        n_res_class  = n_found ? 4'(n_best_c) : NO_CLASS;
                        n_state      = S_DONE;
                    end else begin
                        n_cls = r_cls + CIW'(1);
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_clr_rpt   <= 1'b0;
            r_phase     <= '0;
            r_cls       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_clr_rpt   <= n_clr_rpt;
            r_phase     <= n_phase;
            r_cls       <= n_cls;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // Class and total counts; cleared by reset and by the clear operation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cnt_zero) begin
            r_total <= '0;
            for (int c = 0; c < MAX_CLASSES; c++) begin
                r_cc[c] <= '0;
            end
        end else if (cnt_inc) begin
            if (!(&r_total)) begin
                r_total <= r_total + COUNT_WIDTH'(1);
            end
            if (!(&r_cc[r_cls])) begin
                r_cc[r_cls] <= r_cc[r_cls] + COUNT_WIDTH'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            for (int f = 0; f < FEAT_SLOTS; f++) begin
                r_feat[f] <= in_feat[f];
            end
        end
        r_best       <= n_best;
        r_best_c     <= n_best_c;
        r_res_status <= n_res_status;
        r_res_class  <= n_res_class;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_class  <= r_res_class;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out_status;
    assign o_out.predicted_class = r_out_class;
endmodule
`default_nettype wire

// File: hdl/nbt_checker.sv
// Port-level checker for naive_bayes_train_predict and its bind statement.
// Depends on nbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nbt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_status,
    input wire logic [3:0] i_class
);
    import nbt_pkg::*;

    // Only a prediction names a class; every other result carries no class.
    a_class_only_on_predict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != STS_PREDICTED)) |-> (i_class == NO_CLASS))
        else $error("non-predict result carries a class");

    a_predict_has_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == STS_PREDICTED)) |-> (i_class[3] == 1'b0))
        else $error("prediction without a valid class");

    a_status_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status <= STS_NO_DATA))
        else $error("unknown status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)
                                          && $stable(i_class)))
        else $error("stalled result changed");

    // After reset the clearing sweep keeps the input closed for a while.
    a_closed_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_in_ready)
        else $error("input open during clearing sweep");
endmodule

bind naive_bayes_train_predict nbt_checker u_nbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_class     (o_out.predicted_class)
);
`default_nettype wire
